@@ src/hcc_pkg.sv @@
// shared constants for the hsv/rgb colour converter
`default_nettype none
package hcc_pkg;
  localparam int FRAC_BITS_DEF = 15;
  localparam int HUE_BITS      = 16;
  localparam int DIV_MIN_Q     = 17;
  localparam logic OP_HSV2RGB  = 1'b0;
  localparam logic OP_RGB2HSV  = 1'b1;
endpackage
`default_nettype wire

@@ src/hcc_if.sv @@
// valid/ready channel interfaces for colour items and results
`default_nettype none
interface hcc_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] first_channel;
  logic [15:0] second_channel;
  logic [15:0] third_channel;
  logic [15:0] alpha_in;
  modport source (output valid, opcode, first_channel, second_channel, third_channel,
                  alpha_in, input ready);
  modport sink (input valid, opcode, first_channel, second_channel, third_channel,
                alpha_in, output ready);
endinterface

interface hcc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_first;
  logic [15:0] out_second;
  logic [15:0] out_third;
  logic [15:0] alpha_out;
  modport source (output valid, out_first, out_second, out_third, alpha_out, input ready);
  modport sink (input valid, out_first, out_second, out_third, alpha_out, output ready);
endinterface
`default_nettype wire

@@ src/hsv_rgb_color_convert.sv @@
// hsv/rgb colour converter top level, one colour per transaction
// path from accepting edge to out valid: front end registers, divider stages, output register
// throughput: one transaction per cycle while no result is stalled; the divider pipeline sets the depth
// a stalled result freezes the whole pipeline, nothing is lost or repeated
// reset (rst_n low, synchronous) clears only the valid bits; data regs are not reset
`default_nettype none
module hsv_rgb_color_convert #(
  parameter int CHANNEL_FRACTION_BITS = hcc_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  hcc_in_if.sink    in_ch,
  hcc_out_if.source out_ch
);
  import hcc_pkg::*;
  localparam int F  = CHANNEL_FRACTION_BITS;
  localparam int CW = F + 1;
  localparam int HW = F + 4;
  // quotient bits shared by both dividers so they line up
  localparam int QW = (CW > DIV_MIN_Q) ? CW : DIV_MIN_Q;
  localparam int L  = QW + 3;

  typedef struct packed {
    logic        op;
    logic [15:0] alpha;
    logic        grey;
    logic        black;
    logic [15:0] mx;
    logic [15:0] c0;
    logic [15:0] c1;
    logic [15:0] c2;
  } sb_t;

  logic          en;
  logic [L-1:0]  vld_r;

  // sideband for the first stages
  logic          op1_r, op2_r;
  logic [15:0]   al1_r, al2_r;

  logic [HW-1:0] num, den;
  logic [CW-1:0] m, mx;
  logic          grey, black;
  logic [15:0]   hsv_rgb [3];

  logic          op3_r, grey3_r, black3_r;
  logic [15:0]   al3_r, mx3_r;
  sb_t           sb_head;
  sb_t           sb_r [QW-1];

  logic [QW-1:0] q_hue, q_sat;
  logic          res_op_r, res_black_r;
  logic [15:0]   res0_r, res1_r, res2_r, res3_r;

  // whole pipe advances unless a result sits unread at the output
  assign en          = !vld_r[L-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[L-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= in_ch.opcode;
      al1_r <= in_ch.alpha_in;
      op2_r <= op1_r;
      al2_r <= al1_r;
    end
  end

  hcc_hsv2rgb #(.FRAC_BITS(F)) u_hsv (
    .clk     (clk),
    .en      (en),
    .hue     (in_ch.first_channel),
    .sat     (in_ch.second_channel),
    .val     (in_ch.third_channel),
    .rgb_out (hsv_rgb)
  );

  hcc_rgb_front #(.FRAC_BITS(F)) u_front (
    .clk     (clk),
    .en      (en),
    .red     (in_ch.first_channel),
    .green   (in_ch.second_channel),
    .blue    (in_ch.third_channel),
    .num_r   (num),
    .den_r   (den),
    .m_r     (m),
    .mx2_r   (mx),
    .grey_r  (grey),
    .black_r (black)
  );

  // hue = num * turn / (6 m)
  hcc_div #(.NW(HW + HUE_BITS), .DW(HW), .QW(QW)) u_div_hue (
    .clk      (clk),
    .en       (en),
    .dividend ({num, {HUE_BITS{1'b0}}}),
    .divisor  (den),
    .quotient (q_hue)
  );

  // saturation = (m << F) / max
  hcc_div #(.NW(CW + F), .DW(CW), .QW(QW)) u_div_sat (
    .clk      (clk),
    .en       (en),
    .dividend ({m, {F{1'b0}}}),
    .divisor  (mx),
    .quotient (q_sat)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      op3_r    <= op2_r;
      al3_r    <= al2_r;
      grey3_r  <= grey;
      black3_r <= black;
      mx3_r    <= 16'(mx);
    end
  end

  // hsv results join the sideband here, both ready at the same stage
  assign sb_head = '{op: op3_r, alpha: al3_r, grey: grey3_r, black: black3_r,
                     mx: mx3_r, c0: hsv_rgb[0], c1: hsv_rgb[1], c2: hsv_rgb[2]};

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= sb_head;
      for (int i = 1; i < QW - 1; i++) sb_r[i] <= sb_r[i-1];
    end
  end

  // output register, masks to 16 bits as the hue quotient can reach a full turn
  always_ff @(posedge clk) begin
    if (en) begin
      res_op_r    <= sb_r[QW-2].op;
      res_black_r <= sb_r[QW-2].black;
      res3_r      <= sb_r[QW-2].alpha;
      if (sb_r[QW-2].op == OP_HSV2RGB) begin
        res0_r <= sb_r[QW-2].c0;
        res1_r <= sb_r[QW-2].c1;
        res2_r <= sb_r[QW-2].c2;
      end else begin
        res0_r <= sb_r[QW-2].grey  ? 16'd0 : 16'(q_hue);
        res1_r <= sb_r[QW-2].black ? 16'd0 : 16'(q_sat);
        res2_r <= sb_r[QW-2].mx;
      end
    end
  end

  assign out_ch.valid      = vld_r[L-1];
  assign out_ch.out_first  = res0_r;
  assign out_ch.out_second = res1_r;
  assign out_ch.out_third  = res2_r;
  assign out_ch.alpha_out  = res3_r;

  // black input yields zero saturation
  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && res_op_r == OP_RGB2HSV && res_black_r |-> out_ch.out_second == 16'd0)
    else $error("black input with nonzero saturation");

  // input side is only held off by an unread result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("input ready disagrees with output stall");

  // an item in the last stage before output reaches the output on advance
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[L-2] |=> out_ch.valid)
    else $error("transaction lost before output");
endmodule
`default_nettype wire

@@ src/hcc_hsv2rgb.sv @@
// three stage hsv to rgb datapath
`default_nettype none
module hcc_hsv2rgb #(
  parameter int FRAC_BITS = hcc_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [15:0] hue,
  input  wire logic [15:0] sat,
  input  wire logic [15:0] val,
  output logic [15:0]      rgb_out [3]
);
  import hcc_pkg::*;
  localparam int CW = FRAC_BITS + 1;
  localparam int XW = (CW > 16) ? CW : 16;
  localparam int PW = 2 * CW;
  localparam logic [XW-1:0] ONE   = XW'(1) << FRAC_BITS;
  localparam logic [XW-1:0] SMALL = XW'(((1 << FRAC_BITS) + 50) / 100);
  localparam logic [18:0] TURN    = 19'd65536;

  logic [18:0]   t6;
  logic [18:0]   centre [3];
  logic [18:0]   gap    [3];
  logic [16:0]   k      [3];
  logic [16+CW-1:0] kw  [3];
  logic [CW-1:0] oc     [3];
  logic [XW-1:0] s_x, v_x, s_c, v_c;

  logic [CW-1:0] oc_r [3];
  logic [CW-1:0] s_r, v1_r, v2_r;
  logic [CW-1:0] q_r  [3];
  logic [PW-1:0] p1   [3];
  logic [PW-1:0] p2   [3];
  logic [CW-1:0] gch  [3];

  always_comb begin
    t6  = 19'(hue) * 19'd6;
    s_x = XW'(sat);
    v_x = XW'(val);
    s_c = (s_x < SMALL) ? SMALL : ((s_x > ONE) ? ONE : s_x);
    v_c = (v_x < SMALL) ? SMALL : ((v_x > ONE) ? ONE : v_x);
    // red uses the upper centre past half a turn
    centre[0] = (hue > 16'd32768) ? 19'(6 * 65536) : 19'd0;
    centre[1] = 19'(2 * 65536);
    centre[2] = 19'(4 * 65536);
    for (int i = 0; i < 3; i++) begin
      gap[i] = (t6 > centre[i]) ? (t6 - centre[i]) : (centre[i] - t6);
      if (gap[i] >= (TURN << 1)) k[i] = 17'd0;
      else if ((TURN << 1) - gap[i] > TURN) k[i] = 17'(TURN);
      else k[i] = 17'((TURN << 1) - gap[i]);
      kw[i] = {k[i], {FRAC_BITS{1'b0}}};
      oc[i] = CW'(ONE) - kw[i][16 +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) oc_r[i] <= oc[i];
      s_r  <= CW'(s_c);
      v1_r <= CW'(v_c);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) p1[i] = PW'(oc_r[i]) * PW'(s_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) q_r[i] <= p1[i][FRAC_BITS +: CW];
      v2_r <= v1_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p2[i]  = PW'(CW'(ONE) - q_r[i]) * PW'(v2_r);
      gch[i] = p2[i][FRAC_BITS +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) rgb_out[i] <= 16'(gch[i]);
    end
  end
endmodule
`default_nettype wire

@@ src/hcc_rgb_front.sv @@
// two stage rgb to hsv front end: clamp, extremes, hue numerator
`default_nettype none
module hcc_rgb_front #(
  parameter int FRAC_BITS = hcc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [15:0]          red,
  input  wire logic [15:0]          green,
  input  wire logic [15:0]          blue,
  output logic [FRAC_BITS+3:0]      num_r,
  output logic [FRAC_BITS+3:0]      den_r,
  output logic [FRAC_BITS:0]        m_r,
  output logic [FRAC_BITS:0]        mx2_r,
  output logic                      grey_r,
  output logic                      black_r
);
  import hcc_pkg::*;
  localparam int CW = FRAC_BITS + 1;
  localparam int XW = (CW > 16) ? CW : 16;
  localparam int HW = CW + 3;
  localparam logic [XW-1:0] ONE = XW'(1) << FRAC_BITS;

  logic [XW-1:0] rx, gx, bx;
  logic [CW-1:0] rc, gc, bc, mxc, mnc;
  logic [CW-1:0] r_r, g_r, b_r, mx_r, mn_r;
  logic [CW-1:0] m, ra, ga, ba;
  logic [HW-1:0] num;

  always_comb begin
    rx  = XW'(red);
    gx  = XW'(green);
    bx  = XW'(blue);
    rc  = CW'((rx > ONE) ? ONE : rx);
    gc  = CW'((gx > ONE) ? ONE : gx);
    bc  = CW'((bx > ONE) ? ONE : bx);
    mxc = rc;
    if (gc > mxc) mxc = gc;
    if (bc > mxc) mxc = bc;
    mnc = rc;
    if (gc < mnc) mnc = gc;
    if (bc < mnc) mnc = bc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r  <= rc;
      g_r  <= gc;
      b_r  <= bc;
      mx_r <= mxc;
      mn_r <= mnc;
    end
  end

  always_comb begin
    m  = mx_r - mn_r;
    ra = r_r - mn_r;
    ga = g_r - mn_r;
    ba = b_r - mn_r;
    if (ra == '0)      num = HW'(ba) + HW'(m) * HW'(3) - HW'(ga);
    else if (ga == '0) num = HW'(ra) + HW'(m) * HW'(5) - HW'(ba);
    else               num = HW'(ga) + HW'(m) - HW'(ra);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r   <= num;
      den_r   <= HW'(m) * HW'(6);
      m_r     <= m;
      mx2_r   <= mx_r;
      grey_r  <= (m == '0);
      black_r <= (mx_r == '0);
    end
  end
endmodule
`default_nettype wire

@@ src/hcc_div.sv @@
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module hcc_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 17
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic [QW-1:0]      quotient
);
  // dividend >> QW must be below the divisor, so the quotient fits QW bits
  logic [NW+QW-1:0] padded;
  logic [DW-1:0]    rem0;
  logic [DW-1:0]    rem_r [QW];
  logic [QW-1:0]    low_r [QW];
  logic [DW-1:0]    d_r   [QW];

  assign padded = {{QW{1'b0}}, dividend};
  assign rem0   = DW'(padded[NW+QW-1:QW]);

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [DW-1:0] rin, din, nrem;
    logic [QW-1:0] lin;
    logic [DW:0]   trial;
    logic          ge;
    if (k == 0) begin : g_first
      assign rin = rem0;
      assign lin = padded[QW-1:0];
      assign din = divisor;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign lin = low_r[k-1];
      assign din = d_r[k-1];
    end
    assign trial = {rin, lin[QW-1]};
    assign ge    = (trial >= {1'b0, din});
    assign nrem  = ge ? DW'(trial - {1'b0, din}) : DW'(trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= nrem;
        low_r[k] <= {lin[QW-2:0], ge};
        d_r[k]   <= din;
      end
    end
  end

  assign quotient = low_r[QW-1];
endmodule
`default_nettype wire

@@ test/tb_hsv_rgb_color_convert.sv @@
// self-checking testbench for the hsv/rgb colour converter
`default_nettype none
module tb_hsv_rgb_color_convert;
  timeunit 1ns;
  timeprecision 1ps;
  import hcc_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint unsigned ONE   = 64'd1 << FB;
  localparam longint unsigned FLOOR = (ONE + 50) / 100;
  localparam longint unsigned TURN  = 64'd65536;
  localparam int N_RANDOM = 1400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic        op;
    logic [15:0] a, b, c, alpha;
  } colour_t;

  typedef struct packed {
    logic [15:0] first, second, third, alpha;
  } converted_t;

  // directed row: colour plus an optional typed-in answer
  typedef struct {
    colour_t    col;
    bit         known;
    converted_t ans;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  hcc_in_if  in_ch();
  hcc_out_if out_ch();

  hsv_rgb_color_convert DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  converted_t pending_colours[$];
  int  error_count = 0;
  int  cycle_count = 0;
  bit  stimulus_done = 1'b0;
  bit  quiet_phase = 1'b0;   // stretch with no idling on either side
  bit  hold_off = 1'b0;      // long receiver stall to fill the pipeline

  // one hue-driven channel: triangle around centre, lerp by s, scale by v
  function automatic longint unsigned channel_from_hue(longint unsigned t,
      longint unsigned centre, longint unsigned s, longint unsigned v);
    longint unsigned gap, k, ch, g;
    gap = (t > centre) ? t - centre : centre - t;
    k = (gap >= 2 * TURN) ? 0 : 2 * TURN - gap;
    if (k > TURN) k = TURN;
    ch = (k * ONE) >> 16;
    g = ONE - (((ONE - ch) * s) >> FB);
    return (g * v) >> FB;
  endfunction

  function automatic converted_t convert_colour(colour_t x);
    converted_t y;
    longint unsigned s, v, t, rc, r, g, bl, mx, mn, m, hue, sat, num;
    y.alpha = x.alpha;
    if (x.op == OP_HSV2RGB) begin
      s = x.b < FLOOR ? FLOOR : (x.b > ONE ? ONE : x.b);
      v = x.c < FLOOR ? FLOOR : (x.c > ONE ? ONE : x.c);
      t = 6 * longint'(x.a);
      // red wraps to the far centre only strictly above one half turn
      rc = (x.a > TURN / 2) ? 6 * TURN : 0;
      y.first  = 16'(channel_from_hue(t, rc, s, v));
      y.second = 16'(channel_from_hue(t, 2 * TURN, s, v));
      y.third  = 16'(channel_from_hue(t, 4 * TURN, s, v));
    end else begin
      r  = x.a > ONE ? ONE : x.a;
      g  = x.b > ONE ? ONE : x.b;
      bl = x.c > ONE ? ONE : x.c;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (bl > mx) mx = bl;
      if (g < mn) mn = g;
      if (bl < mn) mn = bl;
      m = mx - mn;
      sat = 0; hue = 0;
      if (mx != 0) sat = (m << FB) / mx;
      if (m != 0) begin
        if (r == mn)      num = (bl - mn) + 3 * m - (g - mn);
        else if (g == mn) num = (r - mn) + 5 * m - (bl - mn);
        else              num = (g - mn) + m - (r - mn);
        hue = ((num * TURN) / (6 * m)) & 64'hFFFF;
      end
      y.first = 16'(hue); y.second = 16'(sat); y.third = 16'(mx);
    end
    return y;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic colour_t random_colour();
    colour_t x;
    x.op = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: begin
        x.a = 16'($urandom); x.b = 16'($urandom); x.c = 16'($urandom);
      end
      1: begin
        x.a = 16'($urandom_range(0, ONE)); x.b = 16'($urandom_range(0, ONE));
        x.c = 16'($urandom_range(0, ONE));
      end
      2: begin  // ties and greys for the hue branches
        x.a = 16'($urandom_range(0, ONE)); x.b = x.a; x.c = 16'($urandom_range(0, ONE));
        if ($urandom_range(0, 1)) x.c = x.a;
      end
      default: begin
        x.a = 16'($urandom); x.b = 16'($urandom_range(0, 400));
        x.c = 16'($urandom_range(ONE - 4, ONE + 4));
      end
    endcase
    x.alpha = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, ONE));
    return x;
  endfunction

  // drive one colour and hold it until the block takes it
  task automatic send_colour(colour_t x);
    while (!quiet_phase && $urandom_range(0, 99) < 14) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= x.op;
    in_ch.first_channel  <= x.a;
    in_ch.second_channel <= x.b;
    in_ch.third_channel  <= x.c;
    in_ch.alpha_in       <= x.alpha;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_colours.push_back(convert_colour(x));
  endtask

  // directed rows: extremes, both directions, grey, black, wrap, half turn
  row_t directed[$];
  function automatic row_t mk(logic op, int a, int b, int c, int al,
      bit known = 0, int f = 0, int s = 0, int t = 0);
    row_t rw;
    rw.col = '{op, 16'(a), 16'(b), 16'(c), 16'(al)};
    rw.known = known;
    rw.ans = '{16'(f), 16'(s), 16'(t), 16'(al)};
    return rw;
  endfunction

  initial begin
    row_t rw;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_HSV2RGB;
    in_ch.first_channel = '0;
    in_ch.second_channel = '0;
    in_ch.third_channel = '0;
    in_ch.alpha_in = '0;
    directed.push_back(mk(OP_RGB2HSV, 0, 0, 0, 0, 1, 0, 0, 0));         // black
    directed.push_back(mk(OP_RGB2HSV, 32768, 32768, 32768, 32768, 1, 0, 0, 32768)); // white
    directed.push_back(mk(OP_RGB2HSV, 65535, 65535, 65535, 65535, 1, 0, 0, 32768)); // saturating
    directed.push_back(mk(OP_RGB2HSV, 32768, 0, 0, 100, 1, 0, 32768, 32768));  // pure red wraps
    directed.push_back(mk(OP_RGB2HSV, 0, 32768, 0, 0));
    directed.push_back(mk(OP_RGB2HSV, 0, 0, 32768, 0));
    directed.push_back(mk(OP_RGB2HSV, 12345, 12345, 200, 7));
    directed.push_back(mk(OP_RGB2HSV, 1, 0, 0, 7));
    directed.push_back(mk(OP_RGB2HSV, 0, 65535, 1, 7));
    directed.push_back(mk(OP_HSV2RGB, 0, 32768, 32768, 32768, 1, 32768, 0, 0)); // pure red
    directed.push_back(mk(OP_HSV2RGB, 0, 0, 0, 0));                    // clamp to floor
    directed.push_back(mk(OP_HSV2RGB, 65535, 65535, 65535, 65535));
    directed.push_back(mk(OP_HSV2RGB, 32768, 32768, 32768, 1));        // exactly one half
    directed.push_back(mk(OP_HSV2RGB, 32769, 32768, 32768, 1));
    directed.push_back(mk(OP_HSV2RGB, 21845, 20000, 30000, 2));
    directed.push_back(mk(OP_HSV2RGB, 43691, 327, 329, 3));
    directed.push_back(mk(OP_HSV2RGB, 10923, 32769, 328, 4));
    directed.push_back(mk(OP_HSV2RGB, 54613, 16384, 16384, 65535));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      rw = directed[i];
      send_colour(rw.col);
      // typed-in answers replace the predicted one
      if (rw.known) begin
        void'(pending_colours.pop_back());
        pending_colours.push_back(rw.ans);
      end
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      quiet_phase = (i >= 300 && i < 500);
      if (i == 700) hold_off = 1'b1;
      send_colour(random_colour());
    end
    in_ch.valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      out_ch.ready <= quiet_phase || ($urandom_range(0, 99) >= 14);
      @(posedge clk);
    end
  end

  // check each accepted result against the oldest expectation
  always @(posedge clk) begin
    converted_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_colours.size() == 0) begin
        $display("unexpected result transaction at cycle %0d", cycle_count);
        error_count++;
      end else begin
        want = pending_colours.pop_front();
        if (out_ch.out_first !== want.first)  report_mismatch("first", out_ch.out_first, want.first);
        if (out_ch.out_second !== want.second)
          report_mismatch("second", out_ch.out_second, want.second);
        if (out_ch.out_third !== want.third)  report_mismatch("third", out_ch.out_third, want.third);
        if (out_ch.alpha_out !== want.alpha)  report_mismatch("alpha", out_ch.alpha_out, want.alpha);
      end
    end
  end

  // run end: drain, settle, verdict; or timeout
  initial begin
    while (!(stimulus_done && pending_colours.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_colours.size() == 0) $display("tb_hsv_rgb_color_convert: clean");
    else $display("tb_hsv_rgb_color_convert: errors");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("tb_hsv_rgb_color_convert: errors");
      $finish;
    end
  end
endmodule
`default_nettype wire

@@ filelist.f @@
src/hcc_pkg.sv
src/hcc_if.sv
src/hcc_hsv2rgb.sv
src/hcc_rgb_front.sv
src/hcc_div.sv
src/hsv_rgb_color_convert.sv
test/tb_hsv_rgb_color_convert.sv
